// ===== hw/rtl/upi_pkg.sv =====
// Shared types and constants for the unicycle pose integrator.
// Holds angle constants, the CORDIC arctangent table and sequencer codes.
// No dependencies.
package upi_pkg;

   localparam int HEAD_W = 33;
   localparam int ANG_W  = 34;
   localparam int CRD_W  = 33;
   localparam int SUM_W  = 38;
   localparam int PROD_W = 56;

   localparam logic signed [ANG_W-1:0] HALF_PI_A = 34'sd1570796327;
   localparam logic signed [ANG_W-1:0] PI_A      = 34'sd3141592654;
   localparam logic signed [SUM_W-1:0] PI_S      = 38'sd3141592654;
   localparam logic signed [SUM_W-1:0] TWO_PI_S  = 38'sd6283185307;
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef enum logic [3:0] {
      MUL_VDT = 4'b0001,
      MUL_WDT = 4'b0010,
      MUL_HI  = 4'b0100,
      MUL_LO  = 4'b1000
   } mul_sel_type;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_PROD   = 11'b00000000010,
      ST_CSTART = 11'b00000000100,
      ST_CWAIT  = 11'b00000001000,
      ST_MULHI  = 11'b00000010000,
      ST_MULLO  = 11'b00000100000,
      ST_DSTART = 11'b00001000000,
      ST_DWAIT  = 11'b00010000000,
      ST_HEAD   = 11'b00100000000,
      ST_WRAP   = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   function automatic logic [29:0] atan_nrad(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'd785398163;
         5'd1:  r = 30'd463647609;
         5'd2:  r = 30'd244978663;
         5'd3:  r = 30'd124354995;
         5'd4:  r = 30'd62418810;
         5'd5:  r = 30'd31239833;
         5'd6:  r = 30'd15623729;
         5'd7:  r = 30'd7812341;
         5'd8:  r = 30'd3906230;
         5'd9:  r = 30'd1953123;
         5'd10: r = 30'd976562;
         5'd11: r = 30'd488281;
         5'd12: r = 30'd244141;
         5'd13: r = 30'd122070;
         5'd14: r = 30'd61035;
         5'd15: r = 30'd30518;
         5'd16: r = 30'd15259;
         5'd17: r = 30'd7629;
         5'd18: r = 30'd3815;
         5'd19: r = 30'd1907;
         5'd20: r = 30'd954;
         5'd21: r = 30'd477;
         5'd22: r = 30'd238;
         5'd23: r = 30'd119;
         5'd24: r = 30'd60;
         5'd25: r = 30'd30;
         5'd26: r = 30'd15;
         5'd27: r = 30'd7;
         5'd28: r = 30'd4;
         5'd29: r = 30'd2;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/upi_mult.sv =====
// Shared signed multiplier with registered product.
// Operand pairs are picked by the sequencer; depends on upi_pkg.
module upi_mult (
   input  logic                         clock,
   input  upi_pkg::mul_sel_type         sel,
   input  logic [19:0]                  step_us,
   input  logic signed [15:0]           speed,
   input  logic signed [15:0]           turn,
   input  logic [35:0]                  mag_p,
   input  logic [31:0]                  mag_c,
   output logic signed [upi_pkg::PROD_W-1:0] prod_ff
);
   import upi_pkg::*;

   logic signed [37:0] op_a;
   logic signed [17:0] op_b;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      case (sel)
         MUL_VDT: begin
            op_a = {18'd0, step_us};
            op_b = {{2{speed[15]}}, speed};
         end
         MUL_WDT: begin
            op_a = {18'd0, step_us};
            op_b = {{2{turn[15]}}, turn};
         end
         MUL_HI: begin
            op_a = {2'd0, mag_p};
            op_b = {1'b0, mag_c[31:15]};
         end
         MUL_LO: begin
            op_a = {2'd0, mag_p};
            op_b = {3'd0, mag_c[14:0]};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ===== hw/rtl/upi_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Gives cosine and sine in Q1.30 of a nanoradian angle; depends on upi_pkg.
module upi_cordic #(
   parameter int STEPS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [upi_pkg::HEAD_W-1:0]  angle,
   output logic                               done_ff,
   output logic signed [upi_pkg::CRD_W-1:0]   cos_ff,
   output logic signed [upi_pkg::CRD_W-1:0]   sin_ff
);
   import upi_pkg::*;

   localparam int CNT_W = $clog2(STEPS + 1);

   logic signed [CRD_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in, ang_ext;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    busy_ff, flip_ff;
   logic [4:0]              idx;
   logic signed [ANG_W-1:0] atan_v;

   assign ang_ext = ANG_W'(angle);
   assign idx     = 5'(cnt_ff);
   assign atan_v  = ANG_W'(atan_nrad(idx));

   always_comb begin
      if (!z_ff[ANG_W-1]) begin
         x_in = x_ff - (y_ff >>> idx);
         y_in = y_ff + (x_ff >>> idx);
         z_in = z_ff - atan_v;
      end else begin
         x_in = x_ff + (y_ff >>> idx);
         y_in = y_ff - (x_ff >>> idx);
         z_in = z_ff + atan_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= CORDIC_GAIN;
         y_ff <= '0;
         if (ang_ext > HALF_PI_A) begin
            z_ff    <= ang_ext - PI_A;
            flip_ff <= 1'b1;
         end else if (ang_ext < -HALF_PI_A) begin
            z_ff    <= ang_ext + PI_A;
            flip_ff <= 1'b1;
         end else begin
            z_ff    <= ang_ext;
            flip_ff <= 1'b0;
         end
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            cos_ff <= flip_ff ? -x_in : x_in;
            sin_ff <= flip_ff ? -y_in : y_in;
         end
      end
   end
endmodule

// ===== hw/rtl/upi_div1000.sv =====
// Division by the constant 1000 through a reciprocal multiply, low half then high half.
// The user keeps the dividend below 2^36 (unchecked); depends on nothing outside this file.
module upi_div1000 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] dividend,
   output logic        done_ff,
   output logic [39:0] quot_ff
);
   // n/1000 = floor((n/8) * RECIP / 2^40), RECIP = ceil(2^40/125) split into 17-bit halves
   localparam logic [16:0] RECIP_HI = 17'd67108;
   localparam logic [16:0] RECIP_LO = 17'd113247;

   logic [32:0] oct_ff;
   logic [32:0] part_ff, part_in;
   logic        lo_ff, hi_ff;
   logic [16:0] factor;
   logic [49:0] prod;
   logic [50:0] total;

   assign factor  = hi_ff ? RECIP_HI : RECIP_LO;
   assign prod    = 50'(oct_ff) * 50'(factor);
   assign part_in = prod[49:17];
   assign total   = 51'(prod) + 51'(part_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff   <= 1'b0;
         hi_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         lo_ff   <= start;
         hi_ff   <= lo_ff;
         done_ff <= hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) oct_ff <= dividend[35:3];
      if (lo_ff) part_ff <= part_in;
      if (hi_ff) quot_ff <= 40'(total[50:23]);
   end
endmodule

// ===== hw/rtl/unicycle_pose_integrator.sv =====
// Top level of the dead-reckoning pose integrator: sequencer and pose state.
// Uses upi_pkg, upi_mult, upi_cordic and upi_div1000.
//
//   channel | direction | transfer when       | payload
//   req     | in        | req_valid&req_ready | operation, speed, turn, step
//   rsp     | out       | rsp_valid&rsp_ready | pose x/y, heading, rate echoes
//
// A step runs the CORDIC iterations, then for each axis a multiply and a reciprocal
// division by 1000, then the heading update, which makes one more pass per 2*pi
// heading wrap. req_ready is high only when idle; the result holds on rsp_ until
// transferred. Synchronous reset zeroes the pose.
module unicycle_pose_integrator #(
   parameter int CORDIC_STEPS  = 24,
   parameter int POSITION_BITS = 40
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [15:0] req_speed_mm_s,
   input  logic signed [15:0] req_turn_mrad_s,
   input  logic [19:0]        req_step_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [39:0] rsp_pos_x_um,
   output logic signed [39:0] rsp_pos_y_um,
   output logic signed [32:0] rsp_heading_nrad,
   output logic signed [15:0] rsp_speed_echo_mm_s,
   output logic signed [15:0] rsp_turn_echo_mrad_s
);
   import upi_pkg::*;

   localparam int PB = POSITION_BITS;
   localparam int DW = 32;
   localparam int SW = ((PB > DW) ? PB : DW) + 1;
   localparam logic signed [SW-1:0] POS_HI = (SW'(1) <<< (PB - 1)) - SW'(1);
   localparam logic signed [SW-1:0] POS_LO = -POS_HI - SW'(1);

   state_type state_ff, state_in;
   mul_sel_type sel;

   logic signed [PB-1:0]     pose_x_ff, pose_y_ff;
   logic signed [HEAD_W-1:0] heading_ff;
   logic signed [SUM_W-1:0]  hsum_ff, dth_ff;
   logic signed [15:0]       speed_ff, turn_ff;
   logic [19:0]              step_ff;
   logic signed [36:0]       p_ff;
   logic                     axis_ff;
   logic [52:0]              hi_ff;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     cord_start, cord_done;
   logic signed [CRD_W-1:0]  cos_v, sin_v, coef;
   logic                     div_start, div_done;
   logic [39:0]              quot, div_n;
   logic [35:0]              mag_p;
   logic [31:0]              mag_c;
   logic [53:0]              tsum;
   logic                     neg;
   logic signed [DW-1:0]     disp;
   logic signed [SW-1:0]     pos_sel, ssum, sat;

   assign mag_p = p_ff[36] ? 36'(-p_ff) : 36'(p_ff);
   assign coef  = axis_ff ? sin_v : cos_v;
   assign mag_c = coef[CRD_W-1] ? 32'(-coef) : 32'(coef);
   assign neg   = p_ff[36] ^ coef[CRD_W-1];
   assign tsum  = {1'b0, hi_ff} + 54'(prod_ff[51:15]) + 54'd16384;
   assign div_n = {1'b0, tsum[53:15]} + 40'd500;
   assign disp  = neg ? -DW'(signed'({1'b0, quot[30:0]})) : DW'(signed'({1'b0, quot[30:0]}));
   assign pos_sel = axis_ff ? SW'(pose_y_ff) : SW'(pose_x_ff);
   assign ssum  = pos_sel + SW'(disp);
   assign sat   = (ssum > POS_HI) ? POS_HI : ((ssum < POS_LO) ? POS_LO : ssum);

   assign cord_start = (state_ff == ST_CSTART);
   assign div_start  = (state_ff == ST_DSTART);

   always_comb begin
      case (state_ff)
         ST_PROD:  sel = MUL_VDT;
         ST_MULHI: sel = MUL_HI;
         ST_MULLO: sel = MUL_LO;
         default:  sel = MUL_WDT;
      endcase
   end

   upi_mult u_mult (
      .clock   (clock),
      .sel     (sel),
      .step_us (step_ff),
      .speed   (speed_ff),
      .turn    (turn_ff),
      .mag_p   (mag_p),
      .mag_c   (mag_c),
      .prod_ff (prod_ff)
   );

   upi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (heading_ff),
      .done_ff (cord_done),
      .cos_ff  (cos_v),
      .sin_ff  (sin_v)
   );

   upi_div1000 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .done_ff  (div_done),
      .quot_ff  (quot)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = req_operation ? ST_OUT : ST_PROD;
         ST_PROD:   state_in = ST_CSTART;
         ST_CSTART: state_in = ST_CWAIT;
         ST_CWAIT:  if (cord_done) state_in = ST_MULHI;
         ST_MULHI:  state_in = ST_MULLO;
         ST_MULLO:  state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DWAIT;
         ST_DWAIT:  if (div_done) state_in = axis_ff ? ST_HEAD : ST_MULHI;
         ST_HEAD:   state_in = ST_WRAP;
         ST_WRAP:   if (hsum_ff < PI_S && hsum_ff > -PI_S) state_in = ST_OUT;
         ST_OUT:    if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         heading_ff <= '0;
         axis_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               axis_ff <= 1'b0;
               if (req_valid && req_operation) begin
                  pose_x_ff  <= '0;
                  pose_y_ff  <= '0;
                  heading_ff <= '0;
               end
            end
            ST_DWAIT: begin
               if (div_done) begin
                  if (axis_ff) pose_y_ff <= PB'(sat);
                  else pose_x_ff <= PB'(sat);
                  axis_ff <= 1'b1;
               end
            end
            ST_WRAP: begin
               if (hsum_ff < PI_S && hsum_ff > -PI_S) heading_ff <= HEAD_W'(hsum_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         speed_ff <= req_speed_mm_s;
         turn_ff  <= req_turn_mrad_s;
         step_ff  <= req_step_us;
      end
      if (state_ff == ST_CSTART) p_ff <= 37'(prod_ff);
      if (state_ff == ST_CWAIT) dth_ff <= SUM_W'(prod_ff);
      if (state_ff == ST_MULLO) hi_ff <= prod_ff[52:0];
      if (state_ff == ST_HEAD) begin
         hsum_ff <= SUM_W'(heading_ff) + dth_ff;
      end else if (state_ff == ST_WRAP) begin
         if (hsum_ff >= PI_S) hsum_ff <= hsum_ff - TWO_PI_S;
         else if (hsum_ff <= -PI_S) hsum_ff <= hsum_ff + TWO_PI_S;
      end
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_pos_x_um         = 40'(pose_x_ff);
   assign rsp_pos_y_um         = 40'(pose_y_ff);
   assign rsp_heading_nrad     = heading_ff;
   assign rsp_speed_echo_mm_s  = speed_ff;
   assign rsp_turn_echo_mrad_s = turn_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (SUM_W'(rsp_heading_nrad) < PI_S && SUM_W'(rsp_heading_nrad) > -PI_S))
      else $error("heading out of range");

   a_zero_pose: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation) |=>
         (rsp_valid && rsp_pos_x_um == '0 && rsp_pos_y_um == '0 && rsp_heading_nrad == '0))
      else $error("pose reset request did not zero pose");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x_um)
         && $stable(rsp_heading_nrad)))
      else $error("result changed while stalled");
endmodule
